// ===== sv/pps_pkg.sv =====
// pps_pkg: types, codes and defaults shared by the priority scheduler
// no dependencies; compiled first
`default_nettype none

package pps_pkg;

   // default number of task slots
   localparam int TASK_SLOTS_DEFAULT = 16;

   // request commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef logic [7:0]  id_type;
   typedef logic [7:0]  prio_type;
   typedef logic [15:0] time_type;

   // result status codes
   typedef enum logic [2:0] {
      RSP_LOADED   = 3'd0,
      RSP_FULL     = 3'd1,
      RSP_IDLE     = 3'd2,
      RSP_RAN      = 3'd3,
      RSP_FINISHED = 3'd4
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      CS_IDLE,
      CS_FIND,
      CS_SCAN,
      CS_DRAIN,
      CS_COMMIT
   } ctl_state_type;

   // one stored task
   typedef struct packed {
      id_type   task_id;
      prio_type priority_val;
      time_type arrival;
      time_type remaining;
      time_type length;
      time_type load_order;
   } entry_type;

   // latched load fields
   typedef struct packed {
      id_type   task_id;
      prio_type priority_req;
      time_type arrival_time;
      time_type run_length;
   } req_type;

   // result payload
   typedef struct packed {
      status_type status;
      id_type     chosen_id;
      time_type   slot_time;
      time_type   finish_time;
      time_type   turnaround;
      time_type   finished_length;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic scan_clear;
      logic find_step;
      logic scan_step;
      logic load_done;
      logic tick_done;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic idx_last;
      logic slot_free;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/pps_if.sv =====
// pps_req_if / pps_rsp_if: valid/ready channels of the priority scheduler
// depends on pps_pkg
`default_nettype none

interface pps_req_if
   import pps_pkg::*;
   ;
   logic     valid;
   logic     ready;
   logic     command;
   id_type   task_id;
   prio_type priority_req;
   time_type arrival_time;
   time_type run_length;

   modport source (output valid, command, task_id, priority_req, arrival_time, run_length,
                   input ready);
   modport sink   (input valid, command, task_id, priority_req, arrival_time, run_length,
                   output ready);
endinterface

interface pps_rsp_if
   import pps_pkg::*;
   ;
   logic       valid;
   logic       ready;
   status_type status;
   id_type     chosen_id;
   time_type   slot_time;
   time_type   finish_time;
   time_type   turnaround;
   time_type   finished_length;

   modport source (output valid, status, chosen_id, slot_time, finish_time, turnaround,
                   finished_length, input ready);
   modport sink   (input valid, status, chosen_id, slot_time, finish_time, turnaround,
                   finished_length, output ready);
endinterface

`default_nettype wire

// ===== sv/pps_ctrl.sv =====
// pps_ctrl: sequencing state machine of the priority scheduler
// depends on pps_pkg; drives pps_datapath through cmd_type / sts_type
`default_nettype none

module pps_ctrl
   import pps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_command,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   ctl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req  = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in       = (req_command == CMD_TICK) ? CS_SCAN : CS_FIND;
            end
         end
         // walk the valid bits for the lowest free slot
         CS_FIND: begin
            if (sts.slot_free || sts.idx_last) begin
               if (sts.rsp_free) begin
                  cmd.load_done = 1'b1;
                  state_in      = CS_IDLE;
               end
            end else begin
               cmd.find_step = 1'b1;
            end
         end
         // one slot read per cycle
         CS_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.idx_last) begin
               state_in = CS_DRAIN;
            end
         end
         // last slot compared here
         CS_DRAIN: begin
            state_in = CS_COMMIT;
         end
         CS_COMMIT: begin
            if (sts.rsp_free) begin
               cmd.tick_done = 1'b1;
               state_in      = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/pps_datapath.sv =====
// pps_datapath: slot memory, valid bits, scan and selection, time, result register
// depends on pps_pkg; commanded by pps_ctrl
`default_nettype none

module pps_datapath
   import pps_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   output sts_type      sts,
   input  wire req_type req_in,
   input  wire logic    rsp_ready,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int IW = $clog2(TASK_SLOTS);

   entry_type          slot_mem [TASK_SLOTS];
   logic [TASK_SLOTS-1:0] valid_ff;
   req_type            req_ff;
   logic [IW-1:0]      idx_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic               rd_pend_ff;
   entry_type          rd_data_ff;
   time_type           time_ff;
   time_type           load_counter_ff;
   logic               found_ff;
   entry_type          best_ff;
   logic [IW-1:0]      best_slot_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   entry_type          mem_wdata;
   logic               eligible;
   logic               better;
   time_type           time_next;
   time_type           rem_next;
   time_type           run_len;

   assign sts.idx_last  = (idx_ff == IW'(TASK_SLOTS - 1));
   assign sts.slot_free = !valid_ff[idx_ff];
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

   assign time_next = (time_ff == '1) ? time_ff : time_ff + 16'd1;
   assign rem_next  = best_ff.remaining - 16'd1;
   assign run_len   = (req_ff.run_length == '0) ? 16'd1 : req_ff.run_length;

   // comparison of the slot read last cycle against the best so far
   always_comb begin
      eligible = valid_ff[rd_idx_ff] && (rd_data_ff.arrival <= time_ff);
      if (!found_ff) begin
         better = 1'b1;
      end else if (rd_data_ff.priority_val != best_ff.priority_val) begin
         better = rd_data_ff.priority_val > best_ff.priority_val;
      end else if (rd_data_ff.arrival != best_ff.arrival) begin
         better = rd_data_ff.arrival < best_ff.arrival;
      end else begin
         better = rd_data_ff.load_order < best_ff.load_order;
      end
   end

   // memory write port: new task on load, updated remaining time on tick
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = best_ff;
      if (cmd.load_done && sts.slot_free) begin
         mem_we               = 1'b1;
         mem_wdata.task_id    = req_ff.task_id;
         mem_wdata.priority_val = req_ff.priority_req;
         mem_wdata.arrival    = req_ff.arrival_time;
         mem_wdata.remaining  = run_len;
         mem_wdata.length     = run_len;
         mem_wdata.load_order = load_counter_ff;
      end else if (cmd.tick_done && found_ff) begin
         mem_we              = 1'b1;
         mem_waddr           = best_slot_ff;
         mem_wdata.remaining = rem_next;
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem[idx_ff];
      rd_idx_ff  <= idx_ff;
   end

   // request latch and best candidate
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_in;
      end
      if (rd_pend_ff && eligible && better) begin
         best_ff      <= rd_data_ff;
         best_slot_ff <= rd_idx_ff;
      end
   end

   // scan control, valid bits, time and load counter
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= '0;
         idx_ff          <= '0;
         rd_pend_ff      <= 1'b0;
         found_ff        <= 1'b0;
         time_ff         <= '0;
         load_counter_ff <= '0;
      end else begin
         rd_pend_ff <= cmd.scan_step;
         if (cmd.scan_clear) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
         end else if (cmd.find_step || cmd.scan_step) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (rd_pend_ff && eligible) begin
            found_ff <= 1'b1;
         end
         if (cmd.load_done && sts.slot_free) begin
            valid_ff[idx_ff] <= 1'b1;
            load_counter_ff  <= load_counter_ff + 16'd1;
         end
         if (cmd.tick_done) begin
            time_ff <= time_next;
            if (found_ff && (rem_next == '0)) begin
               valid_ff[best_slot_ff] <= 1'b0;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_done || cmd.tick_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // next result payload
   always_comb begin
      rsp_in = '0;
      if (cmd.load_done) begin
         rsp_in.status    = sts.slot_free ? RSP_LOADED : RSP_FULL;
         rsp_in.chosen_id = req_ff.task_id;
      end else begin
         rsp_in.slot_time = time_ff;
         if (!found_ff) begin
            rsp_in.status = RSP_IDLE;
         end else begin
            rsp_in.chosen_id = best_ff.task_id;
            if (rem_next == '0) begin
               rsp_in.status          = RSP_FINISHED;
               rsp_in.finish_time     = time_next;
               rsp_in.turnaround      = time_next - best_ff.arrival;
               rsp_in.finished_length = best_ff.length;
            end else begin
               rsp_in.status = RSP_RAN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_done || cmd.tick_done) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // a finishing tick frees its slot
   a_finish_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_done && found_ff && (rem_next == '0) |=> !valid_ff[$past(best_slot_ff)])
      else $error("finished task slot still valid");

   // a successful load occupies the slot it found
   a_load_occupies: assert property (@(posedge clock) disable iff (reset)
      cmd.load_done && sts.slot_free |=> valid_ff[$past(idx_ff)])
      else $error("loaded slot not marked valid");

   // time never runs backwards
   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> time_ff >= $past(time_ff))
      else $error("current time decreased");

   // the load counter only moves on a stored load
   a_counter_on_load: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (load_counter_ff != $past(load_counter_ff))
         |-> $past(cmd.load_done && sts.slot_free))
      else $error("load counter changed without a stored load");

   // a result is never overwritten while still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_done || cmd.tick_done) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");
`endif

endmodule

`default_nettype wire

// ===== sv/preemptive_priority_scheduler.sv =====
// preemptive_priority_scheduler: top level, controller plus datapath
// depends on pps_pkg, pps_if, pps_ctrl, pps_datapath
//
//   channel   dir   handshake     payload
//   req_bus   in    valid/ready   command, task_id, priority_req, arrival_time, run_length
//   rsp_bus   out   valid/ready   status, chosen_id, slot_time, finish_time, turnaround,
//                                 finished_length
//
// a load walks the valid bits one slot a cycle
// a tick reads every slot through the single memory read port
// reset clears the valid bits, the current time and the load counter; no clearing pass
// a new transfer is taken in idle while the previous result waits in the output register
// the final step of an item waits for that register to be free
`default_nettype none

module preemptive_priority_scheduler
   import pps_pkg::*;
#(
   parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
)(
   input  wire logic clock,
   input  wire logic reset,
   pps_req_if.sink   req_bus,
   pps_rsp_if.source rsp_bus
);

   cmd_type cmd;
   sts_type sts;
   req_type req_fields;
   rsp_type rsp_fields;

   assign req_fields.task_id      = req_bus.task_id;
   assign req_fields.priority_req = req_bus.priority_req;
   assign req_fields.arrival_time = req_bus.arrival_time;
   assign req_fields.run_length   = req_bus.run_length;

   assign rsp_bus.status          = rsp_fields.status;
   assign rsp_bus.chosen_id       = rsp_fields.chosen_id;
   assign rsp_bus.slot_time       = rsp_fields.slot_time;
   assign rsp_bus.finish_time     = rsp_fields.finish_time;
   assign rsp_bus.turnaround      = rsp_fields.turnaround;
   assign rsp_bus.finished_length = rsp_fields.finished_length;

   // sequencing
   pps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // storage and arithmetic
   pps_datapath #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_in    (req_fields),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_data  (rsp_fields)
   );

endmodule

`default_nettype wire
